@@ hdl/afp_pkg.sv @@
// afp_pkg: types and constants shared by the imu angle frame parser
// no dependencies; imported by every module of the parser
`default_nettype none

package afp_pkg;

	localparam logic [7:0] FRAME_HEADER = 8'h55;
	localparam logic [7:0] FRAME_TYPE   = 8'h53;
	localparam int unsigned FRAME_LENGTH = 11;

	// frame byte positions
	localparam int unsigned IDX_W = 4;
	localparam logic [IDX_W-1:0] IDX_FIRST_BODY = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_LENGTH - 1);
	localparam int unsigned ANGLE_FIRST = 2;
	localparam int unsigned ANGLE_BYTES = 6;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_TYPE,
		ST_BODY
	} sync_state_t;

	// one completed frame as passed from the front to the back
	typedef struct packed {
		logic               ok;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} frame_rec_t;

endpackage

`default_nettype wire

@@ hdl/imu_angle_frame_parser.sv @@
// imu_angle_frame_parser: top level of the 11-byte imu angle frame parser
// depends on afp_pkg, afp_front, afp_queue and afp_back
//
// channel   direction  handshake          payload
// -------   ---------  -----------------  ---------------------------------------------
// bytes     in         push / full        rx_byte
// results   out        empty / pop        checksum_ok, roll/pitch/yaw_angle, data_valid
//
// one byte item is taken every cycle while full is low; full only rises when the
// record queue between front and back is full, i.e. when results are not popped
// a completed frame reaches the result ports through the queue and the result register:
// queue write as its last byte is taken, result register load once it is empty or popped
// reset (arst_n low) clears sync state, running sum, queue, held angles and flag
// the front keeps taking bytes while a result waits, up to QUEUE_DEPTH frames
`default_nettype none

module imu_angle_frame_parser import afp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2  // frame records buffered, 1 to 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    rx_byte,
	output logic               empty,
	input  wire logic          pop,
	output logic               checksum_ok,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               data_valid
);

	logic       byte_take;   // input item accepted this cycle
	logic       rec_push;    // front finished a frame
	frame_rec_t front_rec;
	logic       mid_full;
	logic       mid_avail;
	frame_rec_t mid_rec;
	logic       mid_take;

	// stall the input only while the record queue cannot take a frame
	assign full      = mid_full;
	assign byte_take = push && !mid_full;

	// front: hunts for header and type, sums bytes, captures angle bytes
	afp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_take (byte_take),
		.rx_byte   (rx_byte),
		.rec_push  (rec_push),
		.rec       (front_rec)
	);

	// queue of completed frames between front and back
	afp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rec_push),
		.wr_data   (front_rec),
		.full      (mid_full),
		.rd_en     (mid_take),
		.rd_data   (mid_rec),
		.not_empty (mid_avail)
	);

	// back: applies good frames to the held angles and presents results
	afp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_avail   (mid_avail),
		.rec         (mid_rec),
		.rec_take    (mid_take),
		.pop         (pop),
		.empty       (empty),
		.checksum_ok (checksum_ok),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.data_valid  (data_valid)
	);

	// a good frame on the output always implies the sticky flag
	a_ok_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && checksum_ok) |-> data_valid)
		else $error("checksum_ok shown without data_valid");

	// the front never finishes a frame into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !mid_full)
		else $error("frame record pushed into full queue");

	// a waiting result is never overwritten by the back
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |-> !mid_take)
		else $error("result register overwritten before pop");

endmodule

`default_nettype wire

@@ hdl/afp_front.sv @@
// afp_front: frame sync, running checksum and angle byte capture
// depends on afp_pkg; emits one frame_rec_t per completed frame
`default_nettype none

module afp_front import afp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_take,
	input  wire logic [7:0] rx_byte,
	output logic            rec_push,
	output frame_rec_t      rec
);

	sync_state_t            state_q, state_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [7:0]             sum_q, sum_d;
	logic [7:0]             body_q [ANGLE_BYTES];
	logic                   body_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (byte_take) begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		sum_d    = sum_q;
		rec_push = 1'b0;
		body_we  = 1'b0;
		case (state_q)
			ST_HUNT: begin
				if (rx_byte == FRAME_HEADER) begin
					sum_d   = rx_byte;
					state_d = ST_TYPE;
				end
			end
			ST_TYPE: begin
				if (rx_byte == FRAME_TYPE) begin
					sum_d   = sum_q + rx_byte;
					idx_d   = IDX_FIRST_BODY;
					state_d = ST_BODY;
				end else if (rx_byte == FRAME_HEADER) begin
					sum_d = rx_byte;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_BODY: begin
				if (idx_q >= IDX_LAST) begin
					rec_push = byte_take;
					sum_d    = '0;
					state_d  = ST_HUNT;
				end else begin
					body_we = byte_take;
					sum_d   = sum_q + rx_byte;
					idx_d   = idx_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// angle bytes sit at fixed frame positions
	for (genvar k = 0; k < ANGLE_BYTES; k++) begin : g_body
		always_ff @(posedge clk) begin
			if (body_we && idx_q == IDX_W'(ANGLE_FIRST + k)) begin
				body_q[k] <= rx_byte;
			end
		end
	end

	always_comb begin
		rec.ok    = (sum_q == rx_byte);
		rec.roll  = {body_q[1], body_q[0]};
		rec.pitch = {body_q[3], body_q[2]};
		rec.yaw   = {body_q[5], body_q[4]};
	end

endmodule

`default_nettype wire

@@ hdl/afp_queue.sv @@
// afp_queue: small first-in first-out queue of frame records
// depends on afp_pkg; decouples the front from the back
`default_nettype none

module afp_queue import afp_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire frame_rec_t wr_data,
	output logic            full,
	input  wire logic       rd_en,
	output frame_rec_t      rd_data,
	output logic            not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	frame_rec_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/afp_back.sv @@
// afp_back: held angles, sticky valid flag and the result register
// depends on afp_pkg; takes frame records from afp_queue
`default_nettype none

module afp_back import afp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_avail,
	input  wire frame_rec_t    rec,
	output logic               rec_take,
	input  wire logic          pop,
	output logic               empty,
	output logic               checksum_ok,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               data_valid
);

	logic               out_valid_q;
	logic signed [15:0] held_roll_q, held_pitch_q, held_yaw_q;
	logic               valid_flag_q;
	logic signed [15:0] roll_n, pitch_n, yaw_n;
	logic               valid_n;

	assign empty    = !out_valid_q;
	assign rec_take = rec_avail && (!out_valid_q || pop);

	always_comb begin
		roll_n  = rec.ok ? rec.roll  : held_roll_q;
		pitch_n = rec.ok ? rec.pitch : held_pitch_q;
		yaw_n   = rec.ok ? rec.yaw   : held_yaw_q;
		valid_n = rec.ok || valid_flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			held_roll_q  <= '0;
			held_pitch_q <= '0;
			held_yaw_q   <= '0;
			valid_flag_q <= 1'b0;
		end else begin
			if (rec_take) begin
				out_valid_q  <= 1'b1;
				held_roll_q  <= roll_n;
				held_pitch_q <= pitch_n;
				held_yaw_q   <= yaw_n;
				valid_flag_q <= valid_n;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			checksum_ok <= rec.ok;
			roll_angle  <= roll_n;
			pitch_angle <= pitch_n;
			yaw_angle   <= yaw_n;
			data_valid  <= valid_n;
		end
	end

endmodule

`default_nettype wire
